### src/assert_macros.svh
// Assertion macros for the checker file.
// Needs clk and rst_n visible in the scope that uses the macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("insertion sorter check failed");

// Antecedent holds -> consequent holds in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("insertion sorter check failed");

`endif

### src/isort_pkg.sv
// Shared types and defaults for the insertion sorter.
// No dependencies.
`default_nettype none

package isort_pkg;

    localparam int DEFAULT_CAPACITY   = 16;
    localparam int DEFAULT_DATA_WIDTH = 32;

    typedef struct packed {
        logic insert;
        logic pop;
    } isort_cmd_t;

    typedef struct packed {
        logic last_one;
        logic out_free;
    } isort_status_t;

endpackage

`default_nettype wire

### src/isort_ctrl.sv
// Controller for the insertion sorter: load and drain phases.
// Depends on isort_pkg.
`default_nettype none

module isort_ctrl
    import isort_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    input  wire logic          s_tlast,
    output logic               s_tready,
    input  wire isort_status_t sts,
    output isort_cmd_t         cmd
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        s_tready   = (state_reg == ST_LOAD);
        cmd.insert = (state_reg == ST_LOAD) && s_tvalid;
        cmd.pop    = (state_reg == ST_DRAIN) && sts.out_free;
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (cmd.pop && sts.last_one)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/isort_datapath.sv
// Datapath: row of sorted cells with parallel compare/shift, count, output register.
// Depends on isort_pkg.
`default_nettype none

module isort_datapath
    import isort_pkg::*;
#(
    parameter int CAPACITY   = DEFAULT_CAPACITY,
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire isort_cmd_t            cmd,
    output isort_status_t              sts,
    input  wire logic [DATA_WIDTH-1:0] in_value,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [DATA_WIDTH-1:0]      out_value,
    output logic                       out_last,
    output logic                       out_drop
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [DATA_WIDTH-1:0] cells_reg [CAPACITY];
    logic signed [DATA_WIDTH-1:0] cells_next [CAPACITY];
    logic signed [DATA_WIDTH-1:0] val_below [CAPACITY];
    logic signed [DATA_WIDTH-1:0] val_above [CAPACITY];
    logic        [CAPACITY-1:0]   gt;
    logic        [CAPACITY-1:0]   gt_below;
    logic signed [DATA_WIDTH-1:0] new_value;

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DATA_WIDTH-1:0] out_value_reg;
    logic                  out_last_reg;
    logic                  out_drop_reg;
    logic                  full;
    logic                  do_insert;

    assign new_value = $signed(in_value);
    assign full      = (count_reg == CW'(CAPACITY));
    assign do_insert = cmd.insert && !full;

    assign sts.last_one = (count_reg == CW'(1));
    assign sts.out_free = !out_valid_reg || m_tready;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign gt[i] = (CW'(i) < count_reg) && (cells_reg[i] > new_value);

        if (i == 0)
        begin : g_first
            assign gt_below[i]  = 1'b0;
            assign val_below[i] = new_value;
        end
        else
        begin : g_rest
            assign gt_below[i]  = gt[i-1];
            assign val_below[i] = cells_reg[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_top
            assign val_above[i] = cells_reg[i];
        end
        else
        begin : g_mid
            assign val_above[i] = cells_reg[i+1];
        end

        // held values above the new one move up; the new one lands at the boundary
        always_comb
        begin
            if (gt_below[i])
            begin
                cells_next[i] = val_below[i];
            end
            else if (gt[i] || (count_reg == CW'(i)))
            begin
                cells_next[i] = new_value;
            end
            else
            begin
                cells_next[i] = cells_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (do_insert)
            begin
                cells_reg[i] <= cells_next[i];
            end
            else if (cmd.pop)
            begin
                cells_reg[i] <= val_above[i];
            end
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        if (cmd.insert)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.pop)
        begin
            count_next     = count_reg - CW'(1);
            out_valid_next = 1'b1;
            if (sts.last_one)
            begin
                ovf_next = 1'b0;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            out_value_reg <= cells_reg[0];
            out_last_reg  <= sts.last_one;
            out_drop_reg  <= ovf_reg;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_drop  = out_drop_reg;

endmodule

`default_nettype wire

### src/insertion_sorter.sv
// Top level of the insertion sorter: controller plus cell datapath.
// Depends on isort_pkg, isort_ctrl, isort_datapath.
//
//   channel  | direction | tdata            | tlast      | tuser
//   ---------+-----------+------------------+------------+--------
//   s_axis   | in        | value            | is_final   | -
//   m_axis   | out       | sorted_value     | end_of_run | dropped
//
// Load: one beat per cycle, compared to all cells in parallel, inserted unless full.
// Drain: after the final beat, one result per cycle from the bottom cell while the
// output register is free; no input is taken until the last result is registered.
// Output register decouples m_tready stalls; reset empties the store, no clearing pass.
`default_nettype none

module insertion_sorter
    import isort_pkg::*;
#(
    parameter int CAPACITY   = DEFAULT_CAPACITY,
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
    localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // [DATA_WIDTH-1:0] value
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [DATA_WIDTH-1:0] sorted_value
    output logic                    m_tlast,
    output logic                    m_tuser    // [0] dropped
);

    isort_cmd_t            cmd;
    isort_status_t         sts;
    logic [DATA_WIDTH-1:0] out_value;

    isort_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    isort_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_value  (s_tdata[DATA_WIDTH-1:0]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_value (out_value),
        .out_last  (m_tlast),
        .out_drop  (m_tuser)
    );

    assign m_tdata = TDATA_W'(out_value);

endmodule

`default_nettype wire

### src/isort_checker.sv
// Port-level checks for the insertion sorter, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module isort_checker #(
    parameter int TDATA_W = 32
)
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               s_tlast,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic               m_tlast,
    input wire logic               m_tuser
);

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_NEXT(a_final_blocks_input, s_tvalid && s_tready && s_tlast, !s_tready)
    `ASSERT_SAME(a_mid_run_no_input, m_tvalid && !m_tlast, !s_tready)
    `ASSERT_NEXT(a_drop_steady, m_tvalid && m_tready && !m_tlast,
                 !m_tvalid || (m_tuser == $past(m_tuser)))

endmodule

bind insertion_sorter isort_checker #(
    .TDATA_W (TDATA_W)
) u_isort_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
